### rtl/dqnp_pkg.sv
// shared types and constants for the dotted-quad netmask parser
package dqnp_pkg;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam logic [8:0] OCTET_MAX = 9'd255;
    localparam logic [8:0] VAL_SAT   = 9'd256;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic        addr_ok;
        logic [31:0] address;
        logic        mask_ok;
        logic [31:0] mask;
    } t_out;

    typedef enum logic [2:0] {
        TOK_DIGIT,
        TOK_WS,
        TOK_PLUS,
        TOK_MINUS,
        TOK_DOT,
        TOK_OTHER,
        TOK_EOT
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] digit;
    } t_token;

endpackage

### rtl/dotted_quad_netmask_parser.sv
// top level of the dotted-quad address and netmask parser
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------
//  input   | i_valid / o_ready  | i_data : char_code, end_of_text
//  output  | o_valid / i_ready  | o_data : addr_ok, address, mask_ok, mask
//
// one beat per cycle sustained unless a result waits on i_ready; each character
// is one parser update; the end-of-text token passes a queue slot and then the
// result register; a result waiting on i_ready stalls the parser; the two-entry
// token queue takes up to two more beats before o_ready drops
// synchronous active-low reset empties the queue and returns the parser to its start
module dotted_quad_netmask_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dqnp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dqnp_pkg::t_out o_data
);
    import dqnp_pkg::*;

    logic   f_valid, f_ready;
    t_token f_tok;
    logic   q_valid, q_ready;
    t_token q_tok;

    dqnp_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_tok_valid (f_valid),
        .i_tok_ready (f_ready),
        .o_tok       (f_tok)
    );

    dqnp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_tok),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_tok)
    );

    dqnp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .o_tok_ready (q_ready),
        .i_tok       (q_tok),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

### rtl/dqnp_front.sv
// front end: classifies each input beat into a parser token
module dqnp_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  dqnp_pkg::t_in i_data,
    output logic          o_tok_valid,
    input  logic          i_tok_ready,
    output dqnp_pkg::t_token o_tok
);
    import dqnp_pkg::*;

    logic [7:0] c;

    assign c           = i_data.char_code;
    assign o_ready     = i_tok_ready;
    assign o_tok_valid = i_valid;

    always_comb begin
        o_tok.digit = c[3:0] - CH_0[3:0];
        if (i_data.end_of_text) begin
            o_tok.kind = TOK_EOT;
        end else if (c >= CH_0 && c <= CH_9) begin
            o_tok.kind = TOK_DIGIT;
        end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            o_tok.kind = TOK_WS;
        end else if (c == CH_PLUS) begin
            o_tok.kind = TOK_PLUS;
        end else if (c == CH_MINUS) begin
            o_tok.kind = TOK_MINUS;
        end else if (c == CH_DOT) begin
            o_tok.kind = TOK_DOT;
        end else begin
            o_tok.kind = TOK_OTHER;
        end
    end

endmodule

### rtl/dqnp_queue.sv
// short token queue between front end and parser back end
module dqnp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  dqnp_pkg::t_token i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output dqnp_pkg::t_token o_pop_data
);
    import dqnp_pkg::*;

    t_token                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  push;
    logic                  pop;

    assign o_push_ready = r_count != QUEUE_CW'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QUEUE_CW'(1);
                2'b01:   r_count <= r_count - QUEUE_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### rtl/dqnp_back.sv
// back end: dotted-quad parser state and registered result
module dqnp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_tok_valid,
    output logic             o_tok_ready,
    input  dqnp_pkg::t_token i_tok,
    output logic             o_valid,
    input  logic             i_ready,
    output dqnp_pkg::t_out   o_data
);
    import dqnp_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_SIGN,
        PH_DIGITS
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_idx, n_idx;
    logic [8:0]  r_val, n_val;
    logic        r_minus, n_minus;
    logic [31:0] r_packed, n_packed;
    logic        r_failed, n_failed;
    logic        r_out_valid, n_out_valid;
    t_out        r_out, n_out;

    logic        take;
    logic [11:0] val_x10;
    logic        bad_octet;
    logic [31:0] closed;
    logic [31:0] inv;
    logic        ok;

    assign o_tok_ready = !r_out_valid || i_ready;
    assign take        = i_tok_valid && o_tok_ready;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    assign val_x10   = {r_val, 3'b000} + {2'b00, r_val, 1'b0} + {8'h00, i_tok.digit};
    assign bad_octet = (r_val > OCTET_MAX) || (r_minus && r_val != '0);
    assign closed    = {r_packed[23:0], r_val[7:0]};
    assign inv       = ~closed;
    assign ok        = !r_failed && r_phase == PH_DIGITS && r_idx == 2'd3 && !bad_octet;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_val       = r_val;
        n_minus     = r_minus;
        n_packed    = r_packed;
        n_failed    = r_failed;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (take) begin
            if (i_tok.kind == TOK_EOT) begin
                n_out_valid   = 1'b1;
                n_out.addr_ok = ok;
                n_out.address = ok ? closed : '0;
                // ones contiguous from the top when ~addr is of form 0..01..1
                n_out.mask_ok = ok && (((inv + 32'd1) & inv) == '0);
                n_out.mask    = n_out.mask_ok ? closed : '0;
                n_phase       = PH_LEAD;
                n_idx         = '0;
                n_val         = '0;
                n_minus       = 1'b0;
                n_packed      = '0;
                n_failed      = 1'b0;
            end else if (!r_failed) begin
                case (i_tok.kind)
                    TOK_DIGIT: begin
                        n_val   = (val_x10 > {3'b000, VAL_SAT}) ? VAL_SAT : val_x10[8:0];
                        n_phase = PH_DIGITS;
                    end
                    TOK_WS: begin
                        if (r_phase != PH_LEAD) begin
                            n_failed = 1'b1;
                        end
                    end
                    TOK_PLUS, TOK_MINUS: begin
                        if (r_phase == PH_LEAD) begin
                            n_minus = i_tok.kind == TOK_MINUS;
                            n_phase = PH_SIGN;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    TOK_DOT: begin
                        if (r_phase == PH_DIGITS && r_idx != 2'd3) begin
                            if (bad_octet) begin
                                n_failed = 1'b1;
                            end else begin
                                n_packed = closed;
                            end
                            n_idx   = r_idx + 2'd1;
                            n_phase = PH_LEAD;
                            n_val   = '0;
                            n_minus = 1'b0;
                        end else begin
                            n_failed = 1'b1;
                        end
                    end
                    default: n_failed = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_idx       <= '0;
            r_val       <= '0;
            r_minus     <= 1'b0;
            r_packed    <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_idx       <= n_idx;
            r_val       <= n_val;
            r_minus     <= n_minus;
            r_packed    <= n_packed;
            r_failed    <= n_failed;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_val_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val <= VAL_SAT)
        else $error("octet value above saturation");
    a_bad_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.addr_ok |-> r_out.address == '0 && !r_out.mask_ok)
        else $error("failed address reports nonzero payload");
    a_mask_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.mask_ok |-> r_out.addr_ok && r_out.mask == r_out.address)
        else $error("mask disagrees with address");
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_tok.kind == TOK_EOT |=> r_phase == PH_LEAD && r_idx == '0 && !r_failed)
        else $error("parser state not cleared after end of text");
`endif

endmodule

### verif/tb_dotted_quad_netmask_parser.sv
// testbench for the dotted-quad address and netmask parser
module tb_dotted_quad_netmask_parser;
    import dqnp_pkg::*;

    localparam int          RANDOM_BEATS = 1900;
    localparam int          CALM_BEATS   = 300;
    localparam int          LONG_HOLD    = 400;
    localparam int          DRAIN_CYCLES = 20;
    localparam longint      TIMEOUT      = 3000000;
    localparam logic [7:0]  CH_NUL       = 8'h00;

    typedef enum logic [2:0] {
        SCAN_LEAD,
        SCAN_SIGN,
        SCAN_DIGITS
    } t_scan_phase;

    typedef enum logic [2:0] {
        FLAW_DROP,
        FLAW_INSERT,
        FLAW_REPLACE,
        FLAW_CUT,
        FLAW_TAIL
    } t_flaw;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_in    i_data;
    logic   o_valid;
    logic   i_ready;
    t_out   o_data;

    bit          idle_on       = 1'b1;
    bit          long_hold_req = 1'b0;
    bit          text_gaps;
    int          beats_sent    = 0;
    logic [7:0]  text_buf[$];

    dotted_quad_netmask_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    class quad_scoreboard;
        t_scan_phase scan_phase;
        logic [1:0]  octet_idx;
        logic [8:0]  octet_val;
        logic        neg_sign;
        logic [31:0] addr_acc;
        logic        text_bad;
        t_out        expected_quads[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void start_number();
            scan_phase = SCAN_LEAD;
            octet_val  = '0;
            neg_sign   = 1'b0;
        endfunction

        function void restart();
            start_number();
            octet_idx = '0;
            addr_acc  = '0;
            text_bad  = 1'b0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit ones_from_top(logic [31:0] a);
            logic [31:0] inv;
            logic [31:0] inc;
            inv = ~a;
            inc = inv + 32'd1;
            return (inc & inv) == 32'd0;
        endfunction

        function void close_octet();
            if (octet_val > OCTET_MAX || (neg_sign && octet_val != '0))
                text_bad = 1'b1;
            else
                addr_acc = {addr_acc[23:0], octet_val[7:0]};
        endfunction

        function int pending();
            return expected_quads.size();
        endfunction

        function void note_beat(t_in beat);
            logic [7:0]  c;
            int unsigned v;
            t_out        res;
            c = beat.char_code;
            if (beat.end_of_text) begin
                res = '0;
                if (!text_bad && scan_phase == SCAN_DIGITS && octet_idx == 2'd3) begin
                    close_octet();
                    if (!text_bad) begin
                        res.addr_ok = 1'b1;
                        res.address = addr_acc;
                        if (ones_from_top(addr_acc)) begin
                            res.mask_ok = 1'b1;
                            res.mask    = addr_acc;
                        end
                    end
                end
                expected_quads.push_back(res);
                restart();
            end else if (!text_bad) begin
                if (c >= CH_0 && c <= CH_9) begin
                    v = octet_val * 10 + (c - CH_0);
                    octet_val  = (v > VAL_SAT) ? VAL_SAT : 9'(v);
                    scan_phase = SCAN_DIGITS;
                end else if (scan_phase == SCAN_LEAD && is_space(c)) begin
                    // leading whitespace, nothing changes
                end else if (scan_phase == SCAN_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
                    neg_sign   = (c == CH_MINUS);
                    scan_phase = SCAN_SIGN;
                end else if (scan_phase == SCAN_DIGITS && c == CH_DOT && octet_idx < 2'd3) begin
                    close_octet();
                    octet_idx = octet_idx + 2'd1;
                    start_number();
                end else begin
                    text_bad = 1'b1;
                end
            end
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_quad(t_out got);
            t_out exp;
            if (expected_quads.size() == 0) begin
                report($sformatf("result with no text pending: %h", got));
                return;
            end
            exp = expected_quads.pop_front();
            if (got.addr_ok !== exp.addr_ok)
                report($sformatf("addr_ok got %b expected %b", got.addr_ok, exp.addr_ok));
            if (got.address !== exp.address)
                report($sformatf("address got %h expected %h", got.address, exp.address));
            if (got.mask_ok !== exp.mask_ok)
                report($sformatf("mask_ok got %b expected %b", got.mask_ok, exp.mask_ok));
            if (got.mask !== exp.mask)
                report($sformatf("mask got %h expected %h", got.mask, exp.mask));
        endtask
    endclass

    quad_scoreboard sb = new();

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT);
        $display("CHECKS FAILED");
        $finish;
    end

    // both handshakes sampled on the edge, before any driver update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_beat(i_data);
            if (o_valid && i_ready)
                sb.check_quad(o_data);
        end
    end

    // receiver: ready bursts, idle bursts and one long hold-off
    initial begin
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic eot);
        t_in beat;
        beat.char_code   = c;
        beat.end_of_text = eot;
        if (idle_on && text_gaps && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do @(posedge i_clk); while (!o_ready);
        beats_sent++;
    endtask

    task automatic send_text();
        text_gaps = ($urandom_range(0, 2) != 0);
        foreach (text_buf[i])
            send_beat(text_buf[i], 1'b0);
        // the character on the end beat is random, it must be ignored
        send_beat(8'($urandom_range(0, 255)), 1'b1);
        text_buf.delete();
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void push_decimal(int unsigned value);
        logic [7:0] digits[$];
        do begin
            digits.push_front(CH_0 + 8'(value % 10));
            value = value / 10;
        end while (value != 0);
        foreach (digits[i])
            text_buf.push_back(digits[i]);
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    function automatic void push_field(int unsigned value);
        int sel;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(pick_space());
        sel = $urandom_range(0, 23);
        if (sel < 2)
            text_buf.push_back(CH_PLUS);
        else if (sel == 2)
            text_buf.push_back(CH_MINUS);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) text_buf.push_back(CH_0);
        push_decimal(value);
    endfunction

    function automatic int unsigned pick_octet();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return $urandom_range(0, 255);
        else if (sel < 16)
            return ($urandom_range(0, 1) == 0) ? 0 : 255;
        else if (sel < 19)
            return $urandom_range(256, 999);
        else
            return $urandom();
    endfunction

    function automatic void gen_wellformed();
        logic [31:0] quad;
        int unsigned prefix;
        int          k;
        if ($urandom_range(0, 2) == 0) begin
            prefix = $urandom_range(0, 32);
            quad   = (prefix == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - prefix);
            if ($urandom_range(0, 3) == 0)
                quad[$urandom_range(0, 31)] ^= 1'b1;
            for (k = 3; k >= 0; k--) begin
                if (k != 3)
                    text_buf.push_back(CH_DOT);
                push_field(quad[8*k +: 8]);
            end
        end else begin
            for (k = 0; k < 4; k++) begin
                if (k != 0)
                    text_buf.push_back(CH_DOT);
                push_field(pick_octet());
            end
        end
    endfunction

    function automatic void gen_flawed();
        int pos;
        gen_wellformed();
        pos = $urandom_range(0, text_buf.size() - 1);
        case (t_flaw'($urandom_range(0, 4)))
            FLAW_DROP: begin
                text_buf.delete(pos);
            end
            FLAW_INSERT: begin
                text_buf.insert(pos, 8'($urandom_range(0, 255)));
            end
            FLAW_REPLACE: begin
                text_buf[pos] = 8'($urandom_range(0, 255));
            end
            FLAW_CUT: begin
                while (text_buf.size() > pos) void'(text_buf.pop_back());
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: begin
                        // fifth number after another dot
                        text_buf.push_back(CH_DOT);
                        push_decimal($urandom_range(0, 255));
                    end
                    1: text_buf.push_back(pick_space());
                    default: text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        endcase
    endfunction

    function automatic void gen_noise();
        repeat ($urandom_range(0, 20)) begin
            case ($urandom_range(0, 4))
                0: text_buf.push_back(CH_DOT);
                1: text_buf.push_back(CH_0 + 8'($urandom_range(0, 9)));
                2: text_buf.push_back(pick_space());
                default: text_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    initial begin
        int start_beats;
        int sel;
        bit paused;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty text
        send_text();
        // whitespace, minus zero, plus sign, top octet value
        text_buf = '{CH_SPACE, CH_MINUS, CH_0, CH_DOT, CH_PLUS};
        push_decimal(1);
        text_buf.push_back(CH_DOT);
        push_decimal(9);
        text_buf.push_back(CH_DOT);
        push_decimal(255);
        send_text();
        // trailing dot after the fourth number
        text_buf = '{CH_0 + 8'd1, CH_DOT, CH_0 + 8'd2, CH_DOT, CH_0 + 8'd3, CH_DOT,
                     CH_0 + 8'd4, CH_DOT};
        send_text();
        // a zero character matches nothing
        text_buf = '{CH_NUL};
        send_text();
        // negative nonzero number
        text_buf = '{CH_MINUS, CH_0 + 8'd1};
        send_text();
        wait_results_done();

        long_hold_req = 1'b1;
        paused        = 1'b0;
        start_beats   = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            if (beats_sent - start_beats >= RANDOM_BEATS - CALM_BEATS)
                idle_on = 1'b0;
            if (!paused && beats_sent - start_beats >= RANDOM_BEATS / 2) begin
                wait_results_done();
                paused = 1'b1;
            end
            sel = $urandom_range(0, 9);
            if (sel < 7)
                gen_wellformed();
            else if (sel < 9)
                gen_flawed();
            else
                gen_noise();
            send_text();
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
